>>> sv/f2u_pkg.sv
// Shared types and codes for the float pixel to unorm8 packer.
// No dependencies.
package f2u_pkg;

	localparam int unsigned NumLanes = 4;

	typedef enum logic [2:0] {
		FMT_GRAY       = 3'd0,
		FMT_GRAY_ALPHA = 3'd1,
		FMT_RGB        = 3'd2,
		FMT_RGBA       = 3'd3,
		FMT_BGR        = 3'd4,
		FMT_BGRA       = 3'd5
	} fmt_code_t;

	typedef enum logic [1:0] {
		CODEC_PNG  = 2'd0,
		CODEC_JPEG = 2'd1,
		CODEC_WEBP = 2'd2
	} codec_code_t;

	typedef enum logic {
		REG_INPUT_FORMAT = 1'b0,
		REG_TARGET_CODEC = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] input_format;
		logic [1:0] target_codec;
	} cfg_t;

	typedef struct packed {
		logic [31:0] channel_zero;
		logic [31:0] channel_one;
		logic [31:0] channel_two;
		logic [31:0] channel_three;
		logic        final_pixel;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
		logic [2:0] byte_count;
		logic       final_out;
	} pixel_out_t;

endpackage

>>> sv/f2u_cfg.sv
// APB register file for format and codec.
// Depends on f2u_pkg.
module f2u_cfg import f2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_format <= FMT_RGB;
			cfg_q.target_codec <= CODEC_PNG;
		end else if (wr_en) begin
			unique case (idx)
				REG_INPUT_FORMAT: cfg_q.input_format <= pwdata[2:0];
				REG_TARGET_CODEC: cfg_q.target_codec <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INPUT_FORMAT: prdata = {29'd0, cfg_q.input_format};
			REG_TARGET_CODEC: prdata = {30'd0, cfg_q.target_codec};
			default:          prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> sv/f2u_lane.sv
// One quantiser lane: float32 to unorm8 with both float roundings, two stages.
// Depends on f2u_pkg.
module f2u_lane import f2u_pkg::*; (
	input  logic        clk,
	input  logic [31:0] val,
	output logic [7:0]  byte_q
);

	logic [7:0]  expo;
	logic [22:0] frac;
	logic        zero_c, sat_c;

	logic [31:0] prod_s1;
	logic [3:0]  eoff_s1;
	logic        zero_s1, sat_s1;

	assign expo   = val[30:23];
	assign frac   = val[22:0];
	// negatives, non-finite and anything below 2^-10 give 0
	assign zero_c = val[31] || (expo == 8'hFF) || (expo < 8'd117);
	assign sat_c  = (expo >= 8'd127);

	always_ff @(posedge clk) begin
		prod_s1 <= 32'({1'b1, frac}) * 32'd255;
		eoff_s1 <= 4'(expo - 8'd117);
		zero_s1 <= zero_c;
		sat_s1  <= sat_c;
	end

	logic        g1, st1, l1, up1;
	logic [32:0] rnd;
	logic [34:0] xs, ys, yr, low, half, mask;
	logic [3:0]  sh, d;
	logic [5:0]  msb;
	logic        up2;
	logic [7:0]  q;

	always_comb begin
		if (prod_s1[31]) begin
			g1  = prod_s1[7];
			st1 = |prod_s1[6:0];
			l1  = prod_s1[8];
			up1 = g1 & (st1 | l1);
			rnd = {(25'({1'b0, prod_s1[31:8]}) + 25'(up1)), 8'd0};
		end else begin
			g1  = prod_s1[6];
			st1 = |prod_s1[5:0];
			l1  = prod_s1[7];
			up1 = g1 & (st1 | l1);
			rnd = {1'b0, (25'(prod_s1[31:7]) + 25'(up1)), 7'd0};
		end
		// 26 fraction bits: scaled value in fixed point
		sh = 4'd9 - eoff_s1;
		xs = {rnd, 2'b00} >> sh;
		ys = xs + (35'd1 << 25);
		msb = 6'd25;
		for (int i = 26; i <= 33; i++) begin
			if (ys[i]) msb = 6'(i);
		end
		d    = 4'(msb - 6'd23);
		mask = (35'd1 << d) - 35'd1;
		half = 35'd1 << (d - 4'd1);
		low  = ys & mask;
		up2  = (low > half) || ((low == half) && ys[d]);
		yr   = (ys & ~mask) + (35'(up2) << d);
		q    = yr[33:26];
	end

	always_ff @(posedge clk) begin
		byte_q <= zero_s1 ? 8'd0 : (sat_s1 ? 8'd255 : q);
	end

endmodule

>>> sv/f2u_merge.sv
// Output packing: orders lane bytes by format and codec, registers the result.
// Depends on f2u_pkg.
module f2u_merge import f2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic [7:0] lane_byte [NumLanes],
	input  logic       valid_s2,
	input  logic       final_s2,
	output logic       done,
	output pixel_out_t result
);

	pixel_out_t pk;
	logic       done_q;
	logic       expand;

	always_comb begin
		pk = '0;
		pk.final_out = final_s2;
		expand = (cfg.target_codec == CODEC_WEBP) ||
			((cfg.target_codec == CODEC_JPEG) && (cfg.input_format == FMT_GRAY_ALPHA));
		unique case (cfg.input_format)
			FMT_GRAY, FMT_GRAY_ALPHA: begin
				pk.byte_zero = lane_byte[0];
				if (expand) begin
					pk.byte_one   = lane_byte[0];
					pk.byte_two   = lane_byte[0];
					pk.byte_count = 3'd3;
				end else if (cfg.input_format == FMT_GRAY_ALPHA) begin
					pk.byte_one   = lane_byte[1];
					pk.byte_count = 3'd2;
				end else begin
					pk.byte_count = 3'd1;
				end
			end
			FMT_RGBA: begin
				pk.byte_zero  = lane_byte[0];
				pk.byte_one   = lane_byte[1];
				pk.byte_two   = lane_byte[2];
				pk.byte_three = lane_byte[3];
				pk.byte_count = 3'd4;
			end
			FMT_BGR: begin
				pk.byte_zero  = lane_byte[2];
				pk.byte_one   = lane_byte[1];
				pk.byte_two   = lane_byte[0];
				pk.byte_count = 3'd3;
			end
			FMT_BGRA: begin
				pk.byte_zero  = lane_byte[2];
				pk.byte_one   = lane_byte[1];
				pk.byte_two   = lane_byte[0];
				pk.byte_three = lane_byte[3];
				pk.byte_count = 3'd4;
			end
			default: begin
				pk.byte_zero  = lane_byte[0];
				pk.byte_one   = lane_byte[1];
				pk.byte_two   = lane_byte[2];
				pk.byte_count = 3'd3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result <= pk;
	end

	assign done = done_q;

endmodule

>>> sv/float_pixel_to_unorm8_packer.sv
// Float pixel to unorm8 packer, top level: four quantiser lanes, packer, APB regs.
// Depends on f2u_pkg, f2u_cfg, f2u_lane, f2u_merge.
//
// A pixel is taken on any cycle with start high; busy never rises, so one pixel
// per cycle is sustained. Each result appears on result with done high for one
// cycle, after the lane multiply, lane rounding and packing registers.
// The receiver cannot stall. Write the registers only while no pixel is in flight.
module float_pixel_to_unorm8_packer import f2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pixel_in_t   pixel,
	output logic        done,
	output pixel_out_t  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t       cfg;
	logic [7:0] lane_byte [NumLanes];
	logic [31:0] chan [NumLanes];
	logic       valid_s1, valid_s2;
	logic       final_s1, final_s2;
	logic       take;

	assign busy = 1'b0;
	assign take = start & ~busy;

	assign chan[0] = pixel.channel_zero;
	assign chan[1] = pixel.channel_one;
	assign chan[2] = pixel.channel_two;
	assign chan[3] = pixel.channel_three;

	f2u_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	for (genvar l = 0; l < NumLanes; l++) begin : g_lane
		f2u_lane u_lane (.clk(clk), .val(chan[l]), .byte_q(lane_byte[l]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		final_s1 <= pixel.final_pixel;
		final_s2 <= final_s1;
	end

	f2u_merge u_merge (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .lane_byte(lane_byte),
		.valid_s2(valid_s2), .final_s2(final_s2), .done(done), .result(result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> ##1 done) else $error("result strobe missing");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.byte_count != 3'd0 && result.byte_count <= 3'd4))
		else $error("byte count out of range");
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.byte_count != 3'd4) |-> result.byte_three == 8'd0)
		else $error("unused byte not cleared");
	a_noextra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s2)) else $error("spurious result");

endmodule
